[rtl/core/rbms_pkg.sv]
package rbms_pkg;

	localparam int FUNC_W   = 2;
	localparam int KEY_W    = 32;
	localparam int BANK_W   = 4;
	localparam int WORD_W   = KEY_W + 1;
	localparam int CFG_IDX_W = 1;

	typedef logic [FUNC_W-1:0] func_t;
	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [BANK_W-1:0] bank_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// request operations; the unused code behaves as a lookup
	localparam func_t FUNC_INSERT = 2'd0;
	localparam func_t FUNC_ERASE  = 2'd1;
	localparam func_t FUNC_LOOKUP = 2'd2;

	// configuration register indexes
	localparam cfg_idx_t REG_RANGE_LOW  = 1'd0;
	localparam cfg_idx_t REG_RANGE_HIGH = 1'd1;

	localparam key_t RANGE_LOW_RST  = -32'sd1000000;
	localparam key_t RANGE_HIGH_RST = 32'sd1000000;

endpackage

[rtl/core/rbms_if.sv]
interface rbms_req_if;
	logic                 valid;
	logic                 ready;
	rbms_pkg::func_t      func;
	rbms_pkg::key_t       key;

	modport source (output valid, output func, output key, input ready);
	modport sink   (input valid, input func, input key, output ready);
endinterface

interface rbms_rsp_if;
	logic                 valid;
	logic                 ready;
	logic                 found;
	logic                 status;
	rbms_pkg::bank_t      bank;

	modport source (output valid, output found, output status, output bank, input ready);
	modport sink   (input valid, input found, input status, input bank, output ready);
endinterface

[rtl/core/rbms_ram.sv]
module rbms_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/range_banked_membership_set.sv]
// Range-banked membership set.
// Signed 32-bit keys live in NUM_BANKS banks of BANK_ENTRIES slots. The span
// range_low..range_high is cut into NUM_BANKS equal parts; keys below it go to
// bank 0, keys above it to the last bank, a key on a boundary to the lower bank.
// Channels: req carries func (insert, erase, lookup) and key; rsp returns
// found, status (insert refused, bank full) and bank, one beat per request.
// Configuration: cfg_we/cfg_idx/cfg_wdata write range_low (0) or range_high
// (1); the user must write only while the block is idle; the block does not enforce it.
// Sequence: a request walks the boundaries one per cycle in ST_BANK, then
// scans its bank through the slot RAM, one slot a cycle with a registered
// read, then writes back and loads the result register. A new request is
// taken only in ST_IDLE, after the previous request has left ST_DONE.
// Reset: control clears at once, then a clearing pass zeroes all
// NUM_BANKS*BANK_ENTRIES slots, one a cycle; req.ready stays low meanwhile.
// Back-pressure: a new request is taken while a result waits on rsp; the block
// holds the next result (and its write-back) until the waiting beat is taken.
module range_banked_membership_set #(
	parameter int NUM_BANKS    = 4,
	parameter int BANK_ENTRIES = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	rbms_req_if.sink                  req,
	rbms_rsp_if.source                rsp,
	input  logic                      cfg_we,
	input  rbms_pkg::cfg_idx_t        cfg_idx,
	input  logic [rbms_pkg::KEY_W-1:0] cfg_wdata
);

	localparam int SLOT_COUNT = NUM_BANKS * BANK_ENTRIES;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int ENT_W      = $clog2(BANK_ENTRIES);
	localparam int BSEL_W     = $clog2(NUM_BANKS);
	localparam int DIFF_W     = rbms_pkg::KEY_W + 1;
	localparam int MUL_W      = DIFF_W + $clog2(NUM_BANKS) + 1;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_BANK  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]               state_q;
	rbms_pkg::key_t           range_low_q, range_high_q;
	rbms_pkg::func_t          func_q;
	rbms_pkg::key_t           key_q;
	logic signed [MUL_W-1:0]  scaled_q, span_q, acc_q;
	logic [BSEL_W-1:0]        bank_q, j_q;
	logic [SLOT_W-1:0]        clr_q;
	logic [ENT_W:0]           rd_idx_q;
	logic                     rd_vld_s1;
	logic [ENT_W-1:0]         rd_ent_s1;
	logic                     hit_q, free_q;
	logic [ENT_W-1:0]         hit_slot_q, free_slot_q;
	logic                     out_valid_q, found_q, status_q;
	rbms_pkg::bank_t          bank_out_q;

	logic signed [DIFF_W-1:0] diff, span_diff;
	logic signed [MUL_W-1:0]  scaled_d;
	logic [SLOT_W-1:0]        base;
	logic                     accept, out_free, finish, issue;
	logic                     ram_we;
	logic [SLOT_W-1:0]        ram_waddr, ram_raddr;
	logic [rbms_pkg::WORD_W-1:0] ram_wdata, ram_rdata;
	logic                     slot_valid, key_match, last_beat;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || rsp.ready;
	assign finish   = (state_q == ST_DONE) && out_free;

	// exact bank arithmetic: NUM_BANKS*(key-lo) against j*(hi-lo)
	assign diff      = {req.key[rbms_pkg::KEY_W-1], req.key}
	                 - {range_low_q[rbms_pkg::KEY_W-1], range_low_q};
	assign span_diff = {range_high_q[rbms_pkg::KEY_W-1], range_high_q}
	                 - {range_low_q[rbms_pkg::KEY_W-1], range_low_q};
	assign scaled_d  = MUL_W'(diff) * $signed(MUL_W'(NUM_BANKS));

	assign base = SLOT_W'(bank_q) * SLOT_W'(BANK_ENTRIES);

	assign issue     = (state_q == ST_SCAN) && (rd_idx_q < (ENT_W+1)'(BANK_ENTRIES));
	assign ram_raddr = base + SLOT_W'(rd_idx_q[ENT_W-1:0]);
	assign slot_valid = ram_rdata[rbms_pkg::WORD_W-1];
	assign key_match  = (ram_rdata[rbms_pkg::KEY_W-1:0] == key_q);
	assign last_beat  = rd_vld_s1 && (rd_ent_s1 == ENT_W'(BANK_ENTRIES - 1));

	rbms_ram #(
		.WIDTH (rbms_pkg::WORD_W),
		.DEPTH (SLOT_COUNT)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// write port: clearing pass, or the single write-back of a finished request
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (finish) begin
			if (func_q == rbms_pkg::FUNC_INSERT && !hit_q && free_q) begin
				ram_we    = 1'b1;
				ram_waddr = base + SLOT_W'(free_slot_q);
				ram_wdata = {1'b1, key_q};
			end else if (func_q == rbms_pkg::FUNC_ERASE && hit_q) begin
				ram_we    = 1'b1;
				ram_waddr = base + SLOT_W'(hit_slot_q);
				ram_wdata = {1'b0, key_q};
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= rbms_pkg::RANGE_LOW_RST;
			range_high_q <= rbms_pkg::RANGE_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				rbms_pkg::REG_RANGE_LOW:  range_low_q  <= cfg_wdata;
				rbms_pkg::REG_RANGE_HIGH: range_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			bank_q    <= '0;
			j_q       <= '0;
		end else begin
			rd_vld_s1 <= issue;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(SLOT_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						bank_q   <= '0;
						j_q      <= BSEL_W'(1);
						hit_q    <= 1'b0;
						free_q   <= 1'b0;
						rd_idx_q <= '0;
						state_q  <= ST_BANK;
					end
				end
				ST_BANK: begin
					// one boundary per cycle
					if (scaled_q > acc_q) begin
						bank_q <= bank_q + 1'b1;
					end
					j_q <= j_q + 1'b1;
					if (j_q == BSEL_W'(NUM_BANKS - 1)) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (rd_vld_s1) begin
						if (slot_valid && key_match && !hit_q) begin
							hit_q <= 1'b1;
						end
						if (!slot_valid && !free_q) begin
							free_q <= 1'b1;
						end
					end
					if (last_beat) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request payload and scan bookkeeping
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= req.func;
			key_q    <= req.key;
			scaled_q <= scaled_d;
			span_q   <= MUL_W'(span_diff);
			acc_q    <= MUL_W'(span_diff);
		end else if (state_q == ST_BANK) begin
			acc_q <= acc_q + span_q;
		end
		rd_ent_s1 <= rd_idx_q[ENT_W-1:0];
		if (state_q == ST_SCAN && rd_vld_s1) begin
			if (slot_valid && key_match && !hit_q) begin
				hit_slot_q <= rd_ent_s1;
			end
			if (!slot_valid && !free_q) begin
				free_slot_q <= rd_ent_s1;
			end
		end
	end

	// result register: hold until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			found_q    <= hit_q;
			status_q   <= (func_q == rbms_pkg::FUNC_INSERT) && !hit_q && !free_q;
			bank_out_q <= rbms_pkg::BANK_W'(bank_q);
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.found  = found_q;
	assign rsp.status = status_q;
	assign rsp.bank   = bank_out_q;

	a_we_when_owned: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_DONE))
		else $error("slot RAM written outside clear or write-back");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised without a finished request");

	a_refuse_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(status_q && found_q))
		else $error("refused insert reported a present key");

	a_scan_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && last_beat) |=> state_q == ST_DONE)
		else $error("scan did not end after the last slot");

endmodule
